// ----- design/vfcm_pkg.sv -----
// ----------------------------------------------------------------------------
// vfcm_pkg: shared definitions for the voxel face cull mesher
// Grid geometry, field widths, command and state codes, grid request type.
// ----------------------------------------------------------------------------
package vfcm_pkg;

    localparam int SIDE_CELLS     = 16;
    localparam int HEIGHT_CELLS   = 256;
    localparam int TYPE_COUNT     = 64;

    localparam int GRID_CELLS     = SIDE_CELLS * HEIGHT_CELLS * SIDE_CELLS;
    localparam int ADDR_W         = $clog2(GRID_CELLS);

    localparam int TYPE_W         = 6;
    localparam int VCOUNT_W       = 21;
    localparam int VCOUNT_MAX     = (2 ** VCOUNT_W) - 1;
    localparam int FACES          = 6;
    localparam int VERTS_PER_FACE = 4;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_BEGIN = 2'd2,
        CMD_MESH  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // face order of the visibility mask
    typedef enum logic [2:0] {
        F_PZ = 3'd0,
        F_MZ = 3'd1,
        F_MX = 3'd2,
        F_PX = 3'd3,
        F_PY = 3'd4,
        F_MY = 3'd5
    } t_face;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [TYPE_W-1:0] wdata;
    } t_grid_req;

endpackage

// ----- design/vfcm_grid.sv -----
// ----------------------------------------------------------------------------
// vfcm_grid: block type memory of the chunk
// One write or read per cycle, writes ignored while busy; registered read data. Clears itself to air
// after reset, one entry per cycle, and flags busy meanwhile.
// ----------------------------------------------------------------------------
module vfcm_grid
    import vfcm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_grid_req         i_req,
    output logic [TYPE_W-1:0] o_rdata,
    output logic              o_busy
);

    logic [TYPE_W-1:0] r_mem [GRID_CELLS];
    logic [TYPE_W-1:0] r_rdata;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clearing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(GRID_CELLS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clearing;

endmodule

// ----- design/voxel_face_cull_mesher_top.sv -----
// Flow: write and begin go idle, done; read goes idle, scan slot 1, done; mesh goes idle,
//   scan slots 1 to 7, done (mesh on air returns to idle with no result). The input stalls
//   until idle again and done waits out an output stall. A mesh cell does seven grid reads, own cell and six
//   neighbors, through the single read port of the grid memory.
// Reset: synchronous, active low. Afterwards the grid is swept to air, one
//   entry per cycle, with the input stalled; APB writes go on.
// ----------------------------------------------------------------------------
// voxel_face_cull_mesher_top: voxel chunk with per-cell face culling
// Holds the block type grid, serves write/read/begin/mesh requests and
// produces face masks, face counts and base vertex indices.
// ----------------------------------------------------------------------------
module voxel_face_cull_mesher_top
    import vfcm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input requests
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_command,
    input  logic [3:0]          i_pos_x,
    input  logic [7:0]          i_pos_y,
    input  logic [3:0]          i_pos_z,
    input  logic [TYPE_W-1:0]   i_new_type,
    // results
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [TYPE_W-1:0]   o_cell_type,
    output logic [FACES-1:0]    o_face_mask,
    output logic [2:0]          o_face_count,
    output logic [VCOUNT_W-1:0] o_base_vertex,
    output logic                o_chunk_empty,
    output logic                o_mesh_stale,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);

    // scan slots: slot 1 sees the own cell, slots 2..7 the six faces
    localparam logic [2:0] SLOT_CELL = 3'd1;
    localparam logic [2:0] SLOT_LAST = 3'd7;

    t_state              r_state, n_state;
    logic [2:0]          r_slot, n_slot;
    t_cmd                r_cmd, n_cmd;
    logic [3:0]          r_x, n_x;
    logic [7:0]          r_y, n_y;
    logic [3:0]          r_z, n_z;
    logic                r_prev_inb, n_prev_inb;
    logic [TYPE_W-1:0]   r_ctype, n_ctype;
    logic [FACES-1:0]    r_mask, n_mask;
    logic [VCOUNT_W-1:0] r_vcount, n_vcount;
    logic                r_empty, n_empty;
    logic                r_stale, n_stale;
    logic [63:0]         r_transp;

    logic                r_out_valid, n_out_valid;
    logic [TYPE_W-1:0]   r_out_type, n_out_type;
    logic [FACES-1:0]    r_out_mask, n_out_mask;
    logic [2:0]          r_out_count, n_out_count;
    logic [VCOUNT_W-1:0] r_out_base, n_out_base;
    logic                r_out_empty, n_out_empty;
    logic                r_out_stale, n_out_stale;

    t_grid_req           grid_req;
    logic [TYPE_W-1:0]   grid_rdata;
    logic                grid_busy;
    logic                in_acc;
    logic                ctr_inb;
    logic                nb_inb;
    logic [ADDR_W-1:0]   ctr_addr;
    logic [ADDR_W-1:0]   nb_addr;
    logic                cfg_wr;

    function automatic logic [ADDR_W-1:0] cell_addr(input int x, input int y, input int z);
        return ADDR_W'((x * HEIGHT_CELLS + y) * SIDE_CELLS + z);
    endfunction

    vfcm_grid u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (grid_req),
        .o_rdata (grid_rdata),
        .o_busy  (grid_busy)
    );

    // APB: one 64-bit register at byte address 0
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[3];
    assign prdata = paddr[3] ? 64'd0 : r_transp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transp <= 64'd1;
        end else if (cfg_wr) begin
            r_transp <= pwdata;
        end
    end

    assign o_in_stall = !(r_state == ST_IDLE) || grid_busy;
    assign in_acc     = i_in_valid && !o_in_stall;

    // own cell of the incoming request
    always_comb begin
        ctr_inb  = (int'(i_pos_x) < SIDE_CELLS) && (int'(i_pos_y) < HEIGHT_CELLS) &&
                   (int'(i_pos_z) < SIDE_CELLS);
        ctr_addr = cell_addr(int'(i_pos_x), int'(i_pos_y), int'(i_pos_z));
    end

    // neighbor read for the face of the current slot
    always_comb begin
        int    nx, ny, nz;
        t_face fsel;
        nx     = int'(r_x);
        ny     = int'(r_y);
        nz     = int'(r_z);
        fsel   = t_face'(3'(r_slot - 3'd1));
        nb_inb = 1'b0;
        unique case (fsel)
            F_PZ: begin
                nz     = nz + 1;
                nb_inb = nz < SIDE_CELLS;
            end
            F_MZ: begin
                nb_inb = nz != 0;
                nz     = nz - 1;
            end
            F_MX: begin
                nb_inb = nx != 0;
                nx     = nx - 1;
            end
            F_PX: begin
                nx     = nx + 1;
                nb_inb = nx < SIDE_CELLS;
            end
            F_PY: begin
                ny     = ny + 1;
                nb_inb = ny < HEIGHT_CELLS;
            end
            F_MY: begin
                nb_inb = ny != 0;
                ny     = ny - 1;
            end
            default: nb_inb = 1'b0;
        endcase
        nb_addr = nb_inb ? cell_addr(nx, ny, nz) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= '0;
            r_vcount    <= '0;
            r_empty     <= 1'b1;
            r_stale     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_slot      <= n_slot;
            r_vcount    <= n_vcount;
            r_empty     <= n_empty;
            r_stale     <= n_stale;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_x         <= n_x;
        r_y         <= n_y;
        r_z         <= n_z;
        r_prev_inb  <= n_prev_inb;
        r_ctype     <= n_ctype;
        r_mask      <= n_mask;
        r_out_type  <= n_out_type;
        r_out_mask  <= n_out_mask;
        r_out_count <= n_out_count;
        r_out_base  <= n_out_base;
        r_out_empty <= n_out_empty;
        r_out_stale <= n_out_stale;
    end

    always_comb begin
        logic [TYPE_W-1:0]   own_type;
        logic                vis;
        logic [2:0]          pidx;
        logic [2:0]          cnt;
        logic [VCOUNT_W:0]   sum;
        logic                is_mesh;
        n_state     = r_state;
        n_slot      = r_slot;
        n_cmd       = r_cmd;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_prev_inb  = r_prev_inb;
        n_ctype     = r_ctype;
        n_mask      = r_mask;
        n_vcount    = r_vcount;
        n_empty     = r_empty;
        n_stale     = r_stale;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_type  = r_out_type;
        n_out_mask  = r_out_mask;
        n_out_count = r_out_count;
        n_out_base  = r_out_base;
        n_out_empty = r_out_empty;
        n_out_stale = r_out_stale;
        grid_req    = '0;
        grid_req.addr = (r_state == ST_IDLE) ? ctr_addr : nb_addr;
        own_type    = r_prev_inb ? grid_rdata : '0;
        pidx        = 3'(r_slot - 3'd2);
        // face visible: neighbor outside, air, or transparent of another type
        vis         = !r_prev_inb || (grid_rdata == '0) ||
                      (r_transp[grid_rdata] && (grid_rdata != r_ctype));
        cnt         = 3'($countones(r_mask));
        sum         = {1'b0, r_vcount} + (VCOUNT_W + 1)'(int'(cnt) * VERTS_PER_FACE);
        is_mesh     = r_cmd == CMD_MESH;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_cmd      = t_cmd'(i_command);
                    n_x        = i_pos_x;
                    n_y        = i_pos_y;
                    n_z        = i_pos_z;
                    n_mask     = '0;
                    n_ctype    = '0;
                    n_prev_inb = ctr_inb;
                    unique case (t_cmd'(i_command))
                        CMD_WRITE: begin
                            // out of range writes leave grid and flags alone
                            if (ctr_inb && ({1'b0, i_new_type} < (TYPE_W + 1)'(TYPE_COUNT))) begin
                                grid_req.we    = 1'b1;
                                grid_req.wdata = i_new_type;
                                n_stale        = 1'b1;
                                if (i_new_type != '0) begin
                                    n_empty = 1'b0;
                                end
                            end
                            n_state = ST_DONE;
                        end
                        CMD_BEGIN: begin
                            n_vcount = '0;
                            n_stale  = 1'b0;
                            n_state  = ST_DONE;
                        end
                        CMD_READ, CMD_MESH: begin
                            n_slot  = SLOT_CELL;
                            n_state = ST_SCAN;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SCAN: begin
                // issue this slot's neighbor read, judge last slot's data
                n_prev_inb = nb_inb;
                n_slot     = r_slot + 3'd1;
                if (r_slot == SLOT_CELL) begin
                    n_ctype = own_type;
                    if (r_cmd == CMD_READ) begin
                        n_state = ST_DONE;
                    end else if (own_type == '0) begin
                        // mesh on air: no result
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_mask[pidx] = vis;
                    if (r_slot == SLOT_LAST) begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_type  = (is_mesh || r_cmd == CMD_READ) ? r_ctype : '0;
                    n_out_mask  = is_mesh ? r_mask : '0;
                    n_out_count = is_mesh ? cnt : '0;
                    n_out_base  = is_mesh ? r_vcount : '0;
                    n_out_empty = r_empty;
                    n_out_stale = r_stale;
                    if (is_mesh) begin
                        // saturate the vertex counter
                        n_vcount = (sum > (VCOUNT_W + 1)'(VCOUNT_MAX)) ?
                                   VCOUNT_W'(VCOUNT_MAX) : sum[VCOUNT_W-1:0];
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid   = r_out_valid;
    assign o_cell_type   = r_out_type;
    assign o_face_mask   = r_out_mask;
    assign o_face_count  = r_out_count;
    assign o_base_vertex = r_out_base;
    assign o_chunk_empty = r_out_empty;
    assign o_mesh_stale  = r_out_stale;

    // grid writes come only from an accepted write request
    a_write_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        grid_req.we |-> (r_state == ST_IDLE && in_acc))
        else $error("grid write outside an accepted request");

    // nothing is taken while the grid is being cleared
    a_stall_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        grid_busy |-> o_in_stall)
        else $error("input accepted during grid clear");

    // scan never sits in the unused slot
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_slot != 3'd0))
        else $error("scan slot out of range");

    // a new result is only produced from the done state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result raised outside done state");

endmodule
